/* hdl/gdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdw_pkg: shared definitions for the depth-first graph walker
// Sizes of the vertex and entry stores, field widths, codes and record types.
// ----------------------------------------------------------------------------
package gdw_pkg;

	// Store sizes.
	localparam int VERTEX_SLOTS = 64;
	localparam int MAX_ENTRIES  = 256;

	// Fixed field widths of the item ports.
	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;

	// Derived index and counter widths.
	localparam int VTX_W   = $clog2(VERTEX_SLOTS);
	localparam int ENT_W   = $clog2(MAX_ENTRIES);
	localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
	localparam int DEPTH_W = $clog2(VERTEX_SLOTS + 1);

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_VISIT = 2'd0,
		ST_OK    = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_RD_A,
		S_ADD_WR_A,
		S_ADD_RD_B,
		S_ADD_WR_B,
		S_RESP,
		S_W_HEAD,
		S_W_STEP,
		S_W_ENT,
		S_W_POP,
		S_FINAL
	} state_t;

	// One adjacency list entry.
	typedef struct packed {
		logic [NODE_W-1:0] nbr;
		logic [ENT_W-1:0]  next;
		logic              next_ok;
	} entry_t;

	// One saved walk frame: the list cursor of a suspended vertex.
	typedef struct packed {
		logic [ENT_W-1:0] cur;
		logic             cur_ok;
	} frame_t;

endpackage
`default_nettype wire

/* hdl/graph_dfs_walker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_dfs_walker: adjacency-list graph store with a depth-first walker
// Add-edge, search and clear items; a search streams visited vertices.
// ----------------------------------------------------------------------------
// The graph lives in three single-port synchronous memories: list heads per
// vertex, a pool of list entries and the walk stack; list valid bits and
// visited marks are flip-flops, so reset and clear take effect at once and no
// clearing pass is needed. One item is handled at a time. An add-edge item
// reads and writes the list head of each endpoint in turn before its result;
// a clear or a rejected item goes straight to its result. A search loads the
// list head of each reached vertex and unwinds its frame, and reads each list
// entry it scans from the entry memory, whose read data feeds the next entry
// address of the walk. Results leave through an output register, one beat per
// result, and the walk pauses when a new result is due while one waits untaken.
module graph_dfs_walker (
	input  wire        clk,
	input  wire        arst_n,
	// Configuration write channel.
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [6:0] vertex_count,
	// Input item channel.
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] kind,
	input  wire  [5:0] node_a,
	input  wire  [5:0] node_b,
	// Result channel.
	output logic       out_valid,
	input  wire        out_ready,
	output logic [5:0] visited_node,
	output logic [1:0] status,
	output logic       last
);
	import gdw_pkg::*;

	// State registers.
	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  vcount_q;
	logic [VTX_W-1:0]    a_q, b_q;
	status_t             resp_q, resp_d;
	logic [USED_W-1:0]   used_q;
	logic [VERTEX_SLOTS-1:0] head_ok_q;
	logic [VERTEX_SLOTS-1:0] visited_q;
	logic [VTX_W-1:0]    pend_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [ENT_W-1:0]    top_cur_q;
	logic                top_ok_q;

	// Memories and their registered read data.
	logic [ENT_W-1:0] head_mem [VERTEX_SLOTS];
	entry_t           entry_mem [MAX_ENTRIES];
	frame_t           stack_mem [VERTEX_SLOTS];
	logic [ENT_W-1:0] head_rd_q;
	entry_t           ent_rd_q;
	frame_t           stk_rd_q;

	// Memory controls.
	logic             head_rd_en, head_wr_en;
	logic [VTX_W-1:0] head_rd_addr, head_wr_addr;
	logic [ENT_W-1:0] head_wr_data;
	logic             ent_rd_en, ent_wr_en;
	logic [ENT_W-1:0] ent_rd_addr;
	entry_t           ent_wr_data;
	logic             stk_rd_en, stk_wr_en;
	logic [VTX_W-1:0] stk_rd_addr, stk_wr_addr;

	// Output register.
	logic              out_valid_q;
	logic [NODE_W-1:0] out_node_q, out_node_d;
	status_t           out_status_q, out_status_d;
	logic              out_last_q, out_last_d;
	logic              out_load;

	// Helpers.
	logic [COUNT_W-1:0] count_eff;
	logic               accept, out_free;
	logic               a_in, b_in, store_full;
	logic               nbr_in, visit_new;
	logic [VTX_W-1:0]   nbr_idx;
	logic [DEPTH_W-1:0] depth_top, depth_below;
	logic [ENT_W-1:0]   used_idx;

	// The register is always writable.
	assign cfg_ready = 1'b1;

	// Vertex count clamped into the supported range.
	always_comb begin
		if (vcount_q == '0) begin
			count_eff = COUNT_W'(1);
		end else if (vcount_q > COUNT_W'(VERTEX_SLOTS)) begin
			count_eff = COUNT_W'(VERTEX_SLOTS);
		end else begin
			count_eff = vcount_q;
		end
	end

	// Handshake and range checks.
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign a_in        = {1'b0, node_a} < count_eff;
	assign b_in        = {1'b0, node_b} < count_eff;
	assign store_full  = used_q > USED_W'(MAX_ENTRIES - 2);
	assign nbr_idx     = ent_rd_q.nbr[VTX_W-1:0];
	assign nbr_in      = {1'b0, ent_rd_q.nbr} < count_eff;
	assign visit_new   = nbr_in && !visited_q[nbr_idx];
	assign depth_top   = depth_q - DEPTH_W'(1);
	assign depth_below = depth_q - DEPTH_W'(2);
	assign used_idx    = used_q[ENT_W-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory strobes and result selection.
	always_comb begin
		state_d      = state_q;
		resp_d       = ST_OK;
		head_rd_en   = 1'b0;
		head_rd_addr = '0;
		head_wr_en   = 1'b0;
		head_wr_addr = '0;
		head_wr_data = '0;
		ent_rd_en    = 1'b0;
		ent_rd_addr  = '0;
		ent_wr_en    = 1'b0;
		ent_wr_data  = '0;
		stk_rd_en    = 1'b0;
		stk_rd_addr  = '0;
		stk_wr_en    = 1'b0;
		stk_wr_addr  = '0;
		out_load     = 1'b0;
		out_node_d   = '0;
		out_status_d = ST_OK;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_ADD: begin
							if (!(a_in && b_in)) begin
								resp_d  = ST_RANGE;
								state_d = S_RESP;
							end else if (store_full) begin
								resp_d  = ST_FULL;
								state_d = S_RESP;
							end else begin
								state_d = S_ADD_RD_A;
							end
						end
						KIND_SEARCH: begin
							if (!a_in) begin
								resp_d  = ST_RANGE;
								state_d = S_RESP;
							end else begin
								head_rd_en   = 1'b1;
								head_rd_addr = node_a[VTX_W-1:0];
								state_d      = S_W_HEAD;
							end
						end
						KIND_CLEAR: begin
							state_d = S_RESP;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ADD_RD_A: begin
				head_rd_en   = 1'b1;
				head_rd_addr = a_q;
				state_d      = S_ADD_WR_A;
			end
			S_ADD_WR_A: begin
				ent_wr_en    = 1'b1;
				ent_wr_data  = '{nbr: NODE_W'(b_q), next: head_rd_q, next_ok: head_ok_q[a_q]};
				head_wr_en   = 1'b1;
				head_wr_addr = a_q;
				head_wr_data = used_idx;
				state_d      = S_ADD_RD_B;
			end
			S_ADD_RD_B: begin
				head_rd_en   = 1'b1;
				head_rd_addr = b_q;
				state_d      = S_ADD_WR_B;
			end
			S_ADD_WR_B: begin
				ent_wr_en    = 1'b1;
				ent_wr_data  = '{nbr: NODE_W'(a_q), next: head_rd_q, next_ok: head_ok_q[b_q]};
				head_wr_en   = 1'b1;
				head_wr_addr = b_q;
				head_wr_data = used_idx;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = resp_q;
					state_d      = S_IDLE;
				end
			end
			S_W_HEAD: begin
				state_d = S_W_STEP;
			end
			S_W_STEP: begin
				if (top_ok_q) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = top_cur_q;
					state_d     = S_W_ENT;
				end else if (depth_q == DEPTH_W'(1)) begin
					state_d = S_FINAL;
				end else begin
					stk_rd_en   = 1'b1;
					stk_rd_addr = depth_below[VTX_W-1:0];
					state_d     = S_W_POP;
				end
			end
			S_W_ENT: begin
				if (!visit_new) begin
					state_d = S_W_STEP;
				end else if (out_free) begin
					// Hand on the previous visit; the new vertex becomes pending.
					out_load     = 1'b1;
					out_node_d   = NODE_W'(pend_q);
					out_status_d = ST_VISIT;
					out_last_d   = 1'b0;
					stk_wr_en    = 1'b1;
					stk_wr_addr  = depth_top[VTX_W-1:0];
					head_rd_en   = 1'b1;
					head_rd_addr = nbr_idx;
					state_d      = S_W_HEAD;
				end
			end
			S_W_POP: begin
				state_d = S_W_STEP;
			end
			S_FINAL: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_node_d   = NODE_W'(pend_q);
					out_status_d = ST_VISIT;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= COUNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= vertex_count;
		end
	end

	// Graph and walk control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			head_ok_q <= '0;
			visited_q <= '0;
			depth_q   <= '0;
			top_ok_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && kind == KIND_CLEAR) begin
						used_q    <= '0;
						head_ok_q <= '0;
						visited_q <= '0;
						depth_q   <= '0;
					end else if (accept && kind == KIND_SEARCH && a_in) begin
						// Fresh marks with only the start vertex set.
						visited_q <= VERTEX_SLOTS'(1) << node_a[VTX_W-1:0];
						depth_q   <= DEPTH_W'(1);
					end
				end
				S_ADD_WR_A: begin
					head_ok_q[a_q] <= 1'b1;
					used_q         <= used_q + USED_W'(1);
				end
				S_ADD_WR_B: begin
					head_ok_q[b_q] <= 1'b1;
					used_q         <= used_q + USED_W'(1);
				end
				S_W_HEAD: begin
					top_ok_q <= head_ok_q[pend_q];
				end
				S_W_STEP: begin
					if (!top_ok_q && depth_q != DEPTH_W'(1)) begin
						depth_q <= depth_top;
					end
				end
				S_W_ENT: begin
					if (!visit_new) begin
						top_ok_q <= ent_rd_q.next_ok;
					end else if (out_free) begin
						visited_q[nbr_idx] <= 1'b1;
						depth_q            <= depth_q + DEPTH_W'(1);
					end
				end
				S_W_POP: begin
					top_ok_q <= stk_rd_q.cur_ok;
				end
				default: begin
				end
			endcase
		end
	end

	// Item operands and walk payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= node_a[VTX_W-1:0];
			b_q    <= node_b[VTX_W-1:0];
			resp_q <= resp_d;
			pend_q <= node_a[VTX_W-1:0];
		end
		case (state_q)
			S_W_HEAD: top_cur_q <= head_rd_q;
			S_W_ENT: begin
				if (!visit_new) begin
					top_cur_q <= ent_rd_q.next;
				end else if (out_free) begin
					pend_q <= nbr_idx;
				end
			end
			S_W_POP: top_cur_q <= stk_rd_q.cur;
			default: begin
			end
		endcase
	end

	// List head memory.
	always_ff @(posedge clk) begin
		if (head_wr_en) begin
			head_mem[head_wr_addr] <= head_wr_data;
		end
		if (head_rd_en) begin
			head_rd_q <= head_mem[head_rd_addr];
		end
	end

	// Entry pool memory.
	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			entry_mem[used_idx] <= ent_wr_data;
		end
		if (ent_rd_en) begin
			ent_rd_q <= entry_mem[ent_rd_addr];
		end
	end

	// Walk stack memory; the suspended frame keeps the advanced cursor.
	always_ff @(posedge clk) begin
		if (stk_wr_en) begin
			stack_mem[stk_wr_addr] <= '{cur: ent_rd_q.next, cur_ok: ent_rd_q.next_ok};
		end
		if (stk_rd_en) begin
			stk_rd_q <= stack_mem[stk_rd_addr];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_node_q   <= out_node_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign visited_node = out_node_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	// A held result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register loaded while a beat was still held");

	// The walk stack never grows past the vertex store.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(VERTEX_SLOTS))
		else $error("walk stack depth beyond its size");

	// The entry pool never overfills.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(MAX_ENTRIES))
		else $error("entry pool count beyond its size");

	// The pending vertex of a walk is always marked visited.
	a_pend_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_HEAD || state_q == S_W_STEP || state_q == S_FINAL)
		|-> visited_q[pend_q])
		else $error("pending vertex not marked visited");

	// A result without the last flag is followed by more work of the same item.
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_last_d) |=> (state_q != S_IDLE))
		else $error("item ended after a result without the last flag");

endmodule
`default_nettype wire
